// ----- design/necir_pkg.sv -----
// Shared types and constants for the NEC infrared pulse decoder.
`timescale 1ns / 1ps

package necir_pkg;

  localparam int TICK_W        = 16;
  localparam int WORD_W        = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CODE_BITS_DEF = 32;

  // Request codes on req_type
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_ARM  = 1'b1;

  // Result status codes on frame_status
  localparam logic STATUS_ACCEPT = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_BIT    = 2'd2;

  localparam logic [TICK_W-1:0] LEADER_MIN_RST = 16'd0;
  localparam logic [TICK_W-1:0] LEADER_MAX_RST = 16'hFFFF;
  localparam logic [TICK_W-1:0] ONE_BIT_RST    = 16'd0;

  typedef enum logic [1:0] {
    PH_ARMED  = 2'd0,
    PH_LEADER = 2'd1,
    PH_BITS   = 2'd2,
    PH_OFF    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] leader_min;
    logic [TICK_W-1:0] leader_max;
    logic [TICK_W-1:0] one_bit;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              status;
    logic [WORD_W-1:0] word;
  } result_t;

endpackage

// ----- design/necir_core.sv -----
// Frame state machine and bit accumulator of the NEC infrared pulse decoder.
`timescale 1ns / 1ps

module necir_core #(
  parameter int CODE_BITS = necir_pkg::CODE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic                            req_type,
  input  logic [necir_pkg::TICK_W-1:0]    interval_ticks,
  input  necir_pkg::cfg_t                 cfg,
  output necir_pkg::result_t              res
);
  import necir_pkg::*;

  localparam int CNT_W = $clog2(CODE_BITS + 1);
  localparam logic [CNT_W:0] LAST_COUNT = (CNT_W + 1)'(CODE_BITS);

  phase_t             phase;
  phase_t             phase_next;
  logic [CNT_W-1:0]   bit_count;
  logic [CNT_W-1:0]   bit_count_next;
  logic [WORD_W-1:0]  shift_word;
  logic [WORD_W-1:0]  shift_word_next;

  logic [CNT_W:0]     count_inc;
  logic               leader_ok;
  logic               bit_one;
  logic               frame_done;
  logic [WORD_W-1:0]  bit_mask;

  assign count_inc  = {1'b0, bit_count} + (CNT_W + 1)'(1);
  assign leader_ok  = (interval_ticks > cfg.leader_min) && (interval_ticks < cfg.leader_max);
  assign bit_one    = interval_ticks > cfg.one_bit;
  assign frame_done = count_inc >= LAST_COUNT;

  // One-hot position of the current bit; counts past the word store nothing
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      bit_mask[i] = (int'(bit_count) == i);
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (step) begin
      if (req_type == REQ_ARM) begin
        phase_next = PH_ARMED;
      end else begin
        case (phase)
          PH_ARMED:  phase_next = PH_LEADER;
          PH_LEADER: phase_next = leader_ok ? PH_BITS : PH_OFF;
          PH_BITS:   phase_next = frame_done ? PH_OFF : PH_BITS;
          PH_OFF:    phase_next = PH_OFF;
          default:   phase_next = PH_OFF;
        endcase
      end
    end
  end

  // Datapath and result
  always_comb begin
    bit_count_next  = bit_count;
    shift_word_next = shift_word;
    res             = '0;
    res.status      = STATUS_ACCEPT;
    if (step) begin
      if (req_type == REQ_ARM) begin
        bit_count_next = '0;
      end else begin
        case (phase)
          PH_ARMED: begin
            shift_word_next = '0;
            bit_count_next  = '0;
          end
          PH_LEADER: begin
            if (!leader_ok) begin
              bit_count_next = '0;
              res.valid      = 1'b1;
              res.status     = STATUS_REJECT;
              res.word       = '0;
            end
          end
          PH_BITS: begin
            if (bit_one) begin
              shift_word_next = shift_word | bit_mask;
            end
            if (frame_done) begin
              bit_count_next = '0;
              res.valid      = 1'b1;
              res.status     = STATUS_ACCEPT;
              res.word       = bit_one ? (shift_word | bit_mask) : shift_word;
            end else begin
              bit_count_next = count_inc[CNT_W-1:0];
            end
          end
          PH_OFF: begin
            bit_count_next = bit_count;
          end
          default: begin
            bit_count_next = bit_count;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_ARMED;
      bit_count  <= '0;
      shift_word <= '0;
    end else begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_word <= shift_word_next;
    end
  end

endmodule

// ----- design/nec_ir_pulse_decoder_top.sv -----
// Top level of the NEC infrared pulse decoder: handshakes, settings, result register.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready): one item per edge event or arm request.
//     req_type = 0 is an edge carrying interval_ticks since the previous edge;
//     req_type = 1 arms the receiver for a new frame.
//   Output channel (out_valid/out_ready): one item per finished frame, with
//     frame_status (0 accepted, 1 leader rejected) and code_word (bit 0 first).
//   Config channel (cfg_valid/cfg_ready): cfg_index 0 leader_min_ticks,
//     1 leader_max_ticks, 2 one_bit_ticks; other indexes are dropped.
//     cfg_ready is always high; write only while the decoder is idle.
// Timing:
//   Each input item is decoded in the cycle it is accepted; a result appears
//   on the output register in the next cycle. One item per cycle is sustained,
//   bounded only by the single output register.
//   While a result waits unclaimed, in_ready follows out_ready, so input
//   stalls only in the cycles the receiver stalls.
// Reset:
//   rst (synchronous) arms the receiver, clears the bit count and the code
//   accumulator, empties the output register and loads the default settings.

module nec_ir_pulse_decoder_top #(
  parameter int CODE_BITS = necir_pkg::CODE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [necir_pkg::TICK_W-1:0]      interval_ticks,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              frame_status,
  output logic [necir_pkg::WORD_W-1:0]      code_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [necir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [necir_pkg::TICK_W-1:0]      cfg_data
);
  import necir_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    in_fire;

  // Accept a new item whenever the output register is empty or being drained
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Settings registers; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_min <= LEADER_MIN_RST;
      cfg.leader_max <= LEADER_MAX_RST;
      cfg.one_bit    <= ONE_BIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LEADER_MIN: cfg.leader_min <= cfg_data;
        CFG_LEADER_MAX: cfg.leader_max <= cfg_data;
        CFG_ONE_BIT:    cfg.one_bit    <= cfg_data;
        default:        cfg.one_bit    <= cfg.one_bit;
      endcase
    end
  end

  necir_core #(
    .CODE_BITS (CODE_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (in_fire),
    .req_type       (req_type),
    .interval_ticks (interval_ticks),
    .cfg            (cfg),
    .res            (res)
  );

  // Output register: load a fresh result, otherwise drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (res.valid) begin
      frame_status <= res.status;
      code_word    <= res.word;
    end
  end

endmodule
